/* rtl/core/hierarchical_transform_propagate_macros.svh */
// assertion helpers for the transform propagation block
// the asserting module must have i_clk and i_rst_n in scope
`ifndef HIERARCHICAL_TRANSFORM_PROPAGATE_MACROS_SVH
`define HIERARCHICAL_TRANSFORM_PROPAGATE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HTP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("htp assertion failed");

// next-cycle implication
`define HTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("htp assertion failed");

`else

`define HTP_ASSERT_IMPL(label, ante, cons)
`define HTP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/htp_pkg.sv */
`timescale 1ns / 1ps

package htp_pkg;

    localparam int IDX_W        = 8;
    localparam int PIDX_W       = 9;
    localparam int POS_W        = 32;
    localparam int ROT_W        = 16;
    localparam int SCALE_W      = 16;
    localparam int SCALE_SHIFT  = 8;
    localparam int PROD_POS_W   = POS_W + SCALE_W;
    localparam int PROD_SCALE_W = 2 * SCALE_W;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [PIDX_W-1:0] t_pidx;

    typedef struct packed {
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [ROT_W-1:0]   rot;
        logic signed [SCALE_W-1:0] sx;
        logic signed [SCALE_W-1:0] sy;
    } t_xform;

    localparam int XFORM_W = $bits(t_xform);

    // unit scale in 8.8
    localparam logic signed [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) <<< SCALE_SHIFT;

    // a root behaves as a child of an identity parent
    localparam t_xform XFORM_ROOT = '{x: '0, y: '0, rot: '0, sx: SCALE_ONE, sy: SCALE_ONE};
    localparam t_xform XFORM_ZERO = '{x: '0, y: '0, rot: '0, sx: '0, sy: '0};

endpackage

/* rtl/core/htp_if.sv */
`timescale 1ns / 1ps

interface htp_in_if;
    import htp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          node_index;
    logic signed [PIDX_W-1:0]  parent_index;
    logic signed [POS_W-1:0]   local_x;
    logic signed [POS_W-1:0]   local_y;
    logic signed [ROT_W-1:0]   local_rot;
    logic signed [SCALE_W-1:0] local_scale_x;
    logic signed [SCALE_W-1:0] local_scale_y;

    modport source (
        output valid, node_index, parent_index, local_x, local_y,
               local_rot, local_scale_x, local_scale_y,
        input  ready
    );

    modport sink (
        input  valid, node_index, parent_index, local_x, local_y,
               local_rot, local_scale_x, local_scale_y,
        output ready
    );
endinterface

interface htp_out_if;
    import htp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          out_index;
    logic signed [POS_W-1:0]   world_x;
    logic signed [POS_W-1:0]   world_y;
    logic signed [ROT_W-1:0]   world_rot;
    logic signed [SCALE_W-1:0] world_scale_x;
    logic signed [SCALE_W-1:0] world_scale_y;

    modport source (
        output valid, out_index, world_x, world_y, world_rot,
               world_scale_x, world_scale_y,
        input  ready
    );

    modport sink (
        input  valid, out_index, world_x, world_y, world_rot,
               world_scale_x, world_scale_y,
        output ready
    );
endinterface

/* rtl/core/htp_ram.sv */
`timescale 1ns / 1ps

module htp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read before write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/htp_datapath.sv */
`timescale 1ns / 1ps

module htp_datapath (
    input  logic           i_clk,
    input  logic           i_en,
    input  htp_pkg::t_xform i_parent,
    input  htp_pkg::t_xform i_local,
    output htp_pkg::t_xform o_result
);
    import htp_pkg::*;

    logic signed [PROD_POS_W-1:0]   w_mx;
    logic signed [PROD_POS_W-1:0]   w_my;
    logic signed [PROD_SCALE_W-1:0] w_msx;
    logic signed [PROD_SCALE_W-1:0] w_msy;

    logic signed [POS_W-1:0]   r_px;
    logic signed [POS_W-1:0]   r_py;
    logic signed [POS_W-1:0]   r_dx;
    logic signed [POS_W-1:0]   r_dy;
    logic signed [ROT_W-1:0]   r_rot;
    logic signed [SCALE_W-1:0] r_sx;
    logic signed [SCALE_W-1:0] r_sy;

    // products against the parent scale
    assign w_mx  = i_local.x  * i_parent.sx;
    assign w_my  = i_local.y  * i_parent.sy;
    assign w_msx = i_local.sx * i_parent.sx;
    assign w_msy = i_local.sy * i_parent.sy;

    // arithmetic shift then wrap is a plain slice
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= i_parent.x;
            r_py  <= i_parent.y;
            r_dx  <= w_mx[SCALE_SHIFT +: POS_W];
            r_dy  <= w_my[SCALE_SHIFT +: POS_W];
            r_sx  <= w_msx[SCALE_SHIFT +: SCALE_W];
            r_sy  <= w_msy[SCALE_SHIFT +: SCALE_W];
            r_rot <= i_parent.rot + i_local.rot;
        end
    end

    always_comb begin
        o_result.x   = r_px + r_dx;
        o_result.y   = r_py + r_dy;
        o_result.rot = r_rot;
        o_result.sx  = r_sx;
        o_result.sy  = r_sy;
    end

endmodule

/* rtl/core/hierarchical_transform_propagate.sv */
`timescale 1ns / 1ps

// scene graph world transform propagation
// i_in takes one scene node per item in pre-order: its index, its parent index
// (negative for a root) and its local position, rotation and scale. o_out gives
// one item per node with the node's world transform, in input order.
// throughput: one item per cycle, sustained, as long as o_out is not stalled.
// pipeline: the accept edge reads the parent's entry from the transform ram;
// the next stage picks ram data or a forwarded result and multiplies; the
// last stage adds, writes the node's entry back and loads the output register.
// the two results not yet visible in the ram are forwarded, so a child may
// follow its parent directly.
// stall: the whole pipeline holds while the output register is full and not
// taken; i_in.ready stays high as long as the output register drains.
// reset: clears the pipeline and output valid flags only. ram contents are not
// cleared; a parent must be sent before its children. parents at or above
// MAX_NODES read as a zero transform, nodes at or above it are not stored.
module hierarchical_transform_propagate #(
    parameter int MAX_NODES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    htp_in_if.sink    i_in,
    htp_out_if.source o_out
);
    import htp_pkg::*;

    `include "hierarchical_transform_propagate_macros.svh"

    localparam int AW = $clog2(MAX_NODES);

    // pipeline control
    logic w_adv;
    logic w_accept;

    // stage one: ram read returns here
    logic   r_s1_valid;
    t_idx   r_s1_node;
    t_pidx  r_s1_parent;
    t_xform r_s1_local;
    t_xform w_rdata;
    t_xform w_parent;
    logic   w_s1_in_range;

    // stage two: adds and write back
    logic   r_s2_valid;
    t_idx   r_s2_node;
    logic   r_s2_store;
    t_xform w_result;
    logic   w_we;

    // last written entry, still in flight in the ram read
    logic   r_fw_valid;
    t_idx   r_fw_node;
    t_xform r_fw_data;

    // output register
    logic   r_out_valid;
    t_idx   r_out_node;
    t_xform r_out_data;

    // whole pipeline moves when the output register can take an item
    assign w_adv    = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && w_adv;
    assign i_in.ready = w_adv;

    assign w_we = w_adv && r_s2_valid && r_s2_store;

    htp_ram #(
        .WIDTH (XFORM_W),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_s2_node)),
        .i_wdata (w_result),
        .i_re    (w_adv),
        .i_raddr (AW'(i_in.parent_index[IDX_W-1:0])),
        .o_rdata (w_rdata)
    );

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_accept;
            r_s2_valid  <= r_s1_valid;
            r_fw_valid  <= w_we;
            r_out_valid <= r_s2_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_node        <= i_in.node_index;
            r_s1_parent      <= i_in.parent_index;
            r_s1_local.x     <= i_in.local_x;
            r_s1_local.y     <= i_in.local_y;
            r_s1_local.rot   <= i_in.local_rot;
            r_s1_local.sx    <= i_in.local_scale_x;
            r_s1_local.sy    <= i_in.local_scale_y;
            r_s2_node        <= r_s1_node;
            r_s2_store       <= (32'(r_s1_node) < MAX_NODES);
            r_fw_node        <= r_s2_node;
            r_fw_data        <= w_result;
            r_out_node       <= r_s2_node;
            r_out_data       <= w_result;
        end
    end

    // parent select: root, out of range, newest in-flight result, then ram
    assign w_s1_in_range = (32'(r_s1_parent[IDX_W-1:0]) < MAX_NODES);

    always_comb begin
        if (r_s1_parent[PIDX_W-1]) begin
            w_parent = XFORM_ROOT;
        end else if (!w_s1_in_range) begin
            w_parent = XFORM_ZERO;
        end else if (r_s2_valid && r_s2_store
                     && (r_s2_node == r_s1_parent[IDX_W-1:0])) begin
            w_parent = w_result;
        end else if (r_fw_valid && (r_fw_node == r_s1_parent[IDX_W-1:0])) begin
            w_parent = r_fw_data;
        end else begin
            w_parent = w_rdata;
        end
    end

    htp_datapath u_datapath (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_parent (w_parent),
        .i_local  (r_s1_local),
        .o_result (w_result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.out_index     = r_out_node;
    assign o_out.world_x       = r_out_data.x;
    assign o_out.world_y       = r_out_data.y;
    assign o_out.world_rot     = r_out_data.rot;
    assign o_out.world_scale_x = r_out_data.sx;
    assign o_out.world_scale_y = r_out_data.sy;

    // stage two item reaches the output register when the pipeline moves
    `HTP_ASSERT_NEXT(a_s2_to_out, r_s2_valid && w_adv, r_out_valid)

    // stage one item moves into stage two with its index
    `HTP_ASSERT_NEXT(a_s1_to_s2, r_s1_valid && w_adv, r_s2_valid && (r_s2_node == $past(r_s1_node)))

    // ram writes only land inside the table
    `HTP_ASSERT_IMPL(a_we_in_range, w_we, 32'(r_s2_node) < MAX_NODES)

    // a held output keeps its node index, as the pipeline is frozen
    `HTP_ASSERT_NEXT(a_stall_hold, r_out_valid && !o_out.ready, r_out_node == $past(r_out_node))

endmodule

/* dv/htp_world_checker.sv */
`timescale 1ns / 1ps

// watches both channels, predicts each node's world transform and compares
module htp_world_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    htp_in_if    i_node_mon,
    htp_out_if   i_world_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import htp_pkg::*;

    typedef struct packed {
        t_idx   idx;
        t_xform w;
    } t_world_item;

    t_xform      world_store [256];
    t_world_item expected_worlds [$];
    int          fail_count = 0;

    // child of a stored parent; product bits [23:8] and [39:8] are the
    // arithmetic shift by eight cut to the field width
    function automatic t_xform world_of(input t_xform par, input t_xform loc);
        logic signed [PROD_POS_W-1:0]   pos_x_prod;
        logic signed [PROD_POS_W-1:0]   pos_y_prod;
        logic signed [PROD_SCALE_W-1:0] scale_x_prod;
        logic signed [PROD_SCALE_W-1:0] scale_y_prod;
        t_xform                         w;
        pos_x_prod   = $signed(loc.x) * $signed(par.sx);
        pos_y_prod   = $signed(loc.y) * $signed(par.sy);
        scale_x_prod = $signed(par.sx) * $signed(loc.sx);
        scale_y_prod = $signed(par.sy) * $signed(loc.sy);
        w.x   = par.x + pos_x_prod[39:8];
        w.y   = par.y + pos_y_prod[39:8];
        w.rot = par.rot + loc.rot;
        w.sx  = scale_x_prod[23:8];
        w.sy  = scale_y_prod[23:8];
        return w;
    endfunction

    task automatic check_field(input string field, input t_idx idx,
                               input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            if (fail_count < 10)
                $display("mismatch node %0d %s: expected %h, got %h", idx, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_world_item want;
        t_xform      loc;
        t_xform      observed;
        t_xform      predicted;
        if (i_rst_n) begin
            if (i_world_mon.valid && i_world_mon.ready) begin
                observed = '{x: i_world_mon.world_x, y: i_world_mon.world_y,
                             rot: i_world_mon.world_rot, sx: i_world_mon.world_scale_x,
                             sy: i_world_mon.world_scale_y};
                if (expected_worlds.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected world item for node %0d", i_world_mon.out_index);
                    fail_count++;
                end else begin
                    want = expected_worlds.pop_front();
                    check_field("index", want.idx, 32'(want.idx),
                                32'(i_world_mon.out_index));
                    check_field("x", want.idx, want.w.x, observed.x);
                    check_field("y", want.idx, want.w.y, observed.y);
                    check_field("rot", want.idx, 32'(want.w.rot), 32'(observed.rot));
                    check_field("scale_x", want.idx, 32'(want.w.sx), 32'(observed.sx));
                    check_field("scale_y", want.idx, 32'(want.w.sy), 32'(observed.sy));
                end
            end
            if (i_node_mon.valid && i_node_mon.ready) begin
                loc = '{x: i_node_mon.local_x, y: i_node_mon.local_y,
                        rot: i_node_mon.local_rot, sx: i_node_mon.local_scale_x,
                        sy: i_node_mon.local_scale_y};
                // self parent reads the old entry, so read before the write
                if (i_node_mon.parent_index < 0)
                    predicted = loc;
                else
                    predicted = world_of(world_store[i_node_mon.parent_index[7:0]], loc);
                world_store[i_node_mon.node_index] = predicted;
                expected_worlds.push_back(t_world_item'{idx: i_node_mon.node_index,
                                                        w: predicted});
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_worlds.size();
    end

endmodule

/* dv/hierarchical_transform_propagate_tb.sv */
`timescale 1ns / 1ps

// stimulus and verdict for the world transform propagation block
// directed scene nodes first, then random pre-order trees with some noise,
// across phases of sender idling and receiver stalling
module hierarchical_transform_propagate_tb;
    import htp_pkg::*;

    localparam int RANDOM_NODES = 450;
    localparam int PHASE_LEN    = 113;   // random items per idling phase
    localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
    localparam int HOLD_AT      = 40;    // random item before which it starts
    localparam int DRAIN_CYCLES = 12;    // quiet after the last expected item

    logic i_clk;
    logic i_rst_n;

    htp_in_if  node_if ();
    htp_out_if world_if ();

    int fail_count;
    int pending_worlds;

    // idling percentages of the current phase
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // hold-off request, one cycle wide, owned by the stimulus process
    logic hold_req;
    int   hold_left = 0;

    // nodes written since reset, so a parent is never an unwritten entry
    bit   written [256];
    t_idx known_nodes [$];

    // ancestors of the current position in the random pre-order walk
    t_idx   lineage [$];
    t_xform loc;
    t_idx   node;
    t_pidx  parent;
    int     pick;

    hierarchical_transform_propagate #(
        .MAX_NODES(256)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (node_if),
        .o_out  (world_if)
    );

    htp_world_checker world_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_node_mon  (node_if),
        .i_world_mon (world_if),
        .o_fail_count(fail_count),
        .o_pending   (pending_worlds)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, or a long hold-off counted here on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left      <= HOLD_CYCLES;
            world_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            world_if.ready <= 1'b0;
        end else begin
            world_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic t_xform xf(input logic [31:0] x, input logic [31:0] y,
                                  input logic [15:0] rot, input logic [15:0] sx,
                                  input logic [15:0] sy);
        return '{x: x, y: y, rot: rot, sx: sx, sy: sy};
    endfunction

    // positions: full range, the extremes, or modest values
    function automatic logic [31:0] random_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return int'($urandom_range(32'h20_0000)) - 32'sh10_0000;
        endcase
    endfunction

    // scales mostly near unity so deep chains keep meaningful values
    function automatic logic [15:0] random_scale();
        logic [15:0] s;
        case ($urandom_range(9))
            0: s = 16'($urandom);
            1: begin
                case ($urandom_range(3))
                    0: s = 16'h7FFF;
                    1: s = 16'h8000;
                    2: s = 16'h0;
                    default: s = 16'hFFFF;
                endcase
            end
            default: begin
                s = 16'(256 + $urandom_range(128) - 64);
                if ($urandom_range(7) == 0)
                    s = -s;
            end
        endcase
        return s;
    endfunction

    function automatic t_xform random_local();
        return xf(random_pos(), random_pos(), 16'($urandom), random_scale(), random_scale());
    endfunction

    // offer one node after a random gap and wait for it to be taken
    task automatic send_node(input t_idx nd, input t_pidx par, input t_xform lx);
        while ($urandom_range(99) < tx_idle_pct) begin
            node_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        node_if.valid         <= 1'b1;
        node_if.node_index    <= nd;
        node_if.parent_index  <= par;
        node_if.local_x       <= lx.x;
        node_if.local_y       <= lx.y;
        node_if.local_rot     <= lx.rot;
        node_if.local_scale_x <= lx.sx;
        node_if.local_scale_y <= lx.sy;
        @(posedge i_clk);
        while (!node_if.ready)
            @(posedge i_clk);
        if (!written[nd]) begin
            written[nd] = 1'b1;
            known_nodes.push_back(nd);
        end
    endtask

    initial begin
        // sender side known from time zero, ready comes from the receiver process
        i_rst_n               = 1'b0;
        hold_req              = 1'b0;
        node_if.valid         = 1'b0;
        node_if.node_index    = '0;
        node_if.parent_index  = '0;
        node_if.local_x       = '0;
        node_if.local_y       = '0;
        node_if.local_rot     = '0;
        node_if.local_scale_x = '0;
        node_if.local_scale_y = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        // root at the field extremes
        send_node(8'd0, -9'sd1, xf(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h8000));
        // root with the most negative parent index, scale -1.0 on y
        send_node(8'd255, -9'sd256, xf(32'h0, 32'hFFFF_FFFF, 16'h8000, 16'h0100, 16'hFF00));
        // child two items behind its parent; position, rotation and scale wrap
        send_node(8'd1, 9'sd0, xf(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        // child directly behind its parent
        send_node(8'd2, 9'sd1, xf(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000));
        // parent at the highest index
        send_node(8'd3, 9'sd255, xf(32'h1, 32'h1, 16'h1, 16'h0100, 16'h0100));
        // zero local transform under an older parent
        send_node(8'd4, 9'sd0, xf(32'h0, 32'h0, 16'h0, 16'h0, 16'h0));
        // node naming itself as parent, reading its old entry
        send_node(8'd2, 9'sd2, xf(32'h0001_0000, 32'hFFFF_0000, 16'h0100, 16'h0180, 16'h0080));
        // small scales for rounding toward minus infinity
        send_node(8'd10, -9'sd1, xf(32'h0, 32'h0, 16'h0, 16'h0003, 16'hFFFD));
        send_node(8'd11, 9'sd10, xf(32'hFFFF_FFFF, 32'h1, 16'h0, 16'hFFFF, 16'hFFFF));
        send_node(8'd12, 9'sd11, xf(32'hFFFF_0000, 32'h0001_0000, 16'hFFFF, 16'h0100, 16'h0100));
        // root then self parent straight after its own write
        send_node(8'd20, -9'sd5, xf(32'h1234_5678, 32'h9ABC_DEF0, 16'h1234, 16'h0200, 16'hFE80));
        send_node(8'd20, 9'sd20, xf(32'h0000_8000, 32'hFFFF_8000, 16'h4321, 16'h0080, 16'h0100));
        send_node(8'd21, 9'sd20, xf(32'h0002_0000, 32'h0003_0000, 16'h7000, 16'h0100, 16'h0100));
        // alternating index bit patterns
        send_node(8'd170, -9'sd170, xf(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'h0155, 16'hFEAA));
        send_node(8'd85, 9'sd170, xf(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h00AA, 16'h0055));
        send_node(8'd0, 9'sd85, xf(32'h0000_0100, 32'hFFFF_FF00, 16'h0001, 16'h7FFF, 16'h8000));

        // random pre-order walks, with roots, backtracking and noise
        for (int n = 0; n < RANDOM_NODES; n++) begin
            if (n % PHASE_LEN == 0) begin
                case (n / PHASE_LEN)
                    0: begin
                        tx_idle_pct = 0;
                        rx_stall_pct <= 0;
                    end
                    1: begin
                        tx_idle_pct = 53;
                        rx_stall_pct <= 0;
                    end
                    2: begin
                        tx_idle_pct = 0;
                        rx_stall_pct <= 53;
                    end
                    default: begin
                        tx_idle_pct = 29;
                        rx_stall_pct <= 29;
                    end
                endcase
            end
            // long receiver hold-off while the sender keeps offering, so the
            // pipeline fills and the input stalls
            if (n == HOLD_AT) begin
                node_if.valid <= 1'b0;
                hold_req      <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            loc  = random_local();
            pick = $urandom_range(99);
            node = t_idx'($urandom_range(255));
            if (lineage.size() == 0 || pick < 10) begin
                // new tree
                parent = t_pidx'(-int'($urandom_range(256, 1)));
                lineage.delete();
            end else if (pick < 85) begin
                // descend, sometimes after climbing back up a few levels
                while (lineage.size() > 1 && $urandom_range(2) == 0)
                    void'(lineage.pop_back());
                parent = t_pidx'(lineage[$]);
            end else begin
                // noise: any written entry, now and then the node itself
                parent = t_pidx'(known_nodes[$urandom_range(known_nodes.size() - 1)]);
                if ($urandom_range(3) == 0)
                    node = parent[7:0];
            end
            send_node(node, parent, loc);
            if (pick < 85)
                lineage.push_back(node);
        end
        node_if.valid <= 1'b0;

        // drain: every expected item out, then DRAIN_CYCLES of quiet
        @(posedge i_clk);
        while (pending_worlds != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
